// File: sv/sbc_pkg.sv
// Shared types and constants for the swept box collision block.
package sbc_pkg;

  localparam int unsigned TIME_FRAC = 16;
  localparam int unsigned QUOT_BITS = TIME_FRAC + 2;
  localparam int unsigned DIST_W    = 19;
  localparam int unsigned TIME_W    = TIME_FRAC + 3;
  localparam int unsigned MOVE_W    = 13;
  localparam int unsigned REM_W     = 13;
  localparam int unsigned DIV_LAT   = QUOT_BITS + 1;

  localparam logic signed [TIME_W-1:0] TIME_ONE   = TIME_W'(1) <<< TIME_FRAC;
  localparam logic signed [TIME_W-1:0] TIME_LIMIT = TIME_W'(2) <<< TIME_FRAC;

  localparam logic signed [1:0] NORM_POS  = 2'sb01;
  localparam logic signed [1:0] NORM_NEG  = 2'sb11;
  localparam logic signed [1:0] NORM_NONE = 2'sb00;

  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic signed [TIME_W-1:0] time_t;
  typedef logic signed [MOVE_W-1:0] move_t;

  typedef struct packed {
    logic  broad;
    dist_t ent_x;
    dist_t ext_x;
    dist_t ent_y;
    dist_t ext_y;
    move_t mv_x;
    move_t mv_y;
  } sbc_word_t;

endpackage

// File: sv/sbc_front.sv
// Front stage: takes an input word, computes the broadphase flag and axis distances.
module sbc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [16:0]      in_mover_x,
  input  logic signed [16:0]      in_mover_y,
  input  logic        [15:0]      in_mover_width,
  input  logic        [15:0]      in_mover_height,
  input  logic signed [12:0]      in_step_dx,
  input  logic signed [12:0]      in_step_dy,
  input  logic signed [16:0]      in_target_x,
  input  logic signed [16:0]      in_target_y,
  input  logic        [15:0]      in_target_width,
  input  logic        [15:0]      in_target_height,
  input  logic                    q_full,
  output logic                    q_push,
  output sbc_pkg::sbc_word_t      q_word
);
  import sbc_pkg::*;

  logic      fv_r;
  sbc_word_t word_r;
  sbc_word_t word_nxt;
  logic      adv;

  logic signed [19:0] mx, my, mw, mh, dx, dy, tx, ty, tw, th;
  logic signed [19:0] bx, by, bw, bh;

  assign mx = 20'(in_mover_x);
  assign my = 20'(in_mover_y);
  assign mw = 20'($signed({1'b0, in_mover_width}));
  assign mh = 20'($signed({1'b0, in_mover_height}));
  assign dx = 20'(in_step_dx);
  assign dy = 20'(in_step_dy);
  assign tx = 20'(in_target_x);
  assign ty = 20'(in_target_y);
  assign tw = 20'($signed({1'b0, in_target_width}));
  assign th = 20'($signed({1'b0, in_target_height}));

  always_comb begin
    bx = (dx > 0) ? mx : mx + dx;
    by = (dy > 0) ? my : my + dy;
    bw = (dx > 0) ? dx + mw : mw - dx;
    bh = (dy > 0) ? dy + mh : mh - dy;
    word_nxt.broad = !((bx + bw < tx) || (bx > tx + tw) ||
                       (by + bh < ty) || (by > ty + th));
    if (dx > 0) begin
      word_nxt.ent_x = DIST_W'(tx - (mx + mw));
      word_nxt.ext_x = DIST_W'((tx + tw) - mx);
    end else begin
      word_nxt.ent_x = DIST_W'((tx + tw) - mx);
      word_nxt.ext_x = DIST_W'(tx - (mx + mw));
    end
    if (dy > 0) begin
      word_nxt.ent_y = DIST_W'(ty - (my + mh));
      word_nxt.ext_y = DIST_W'((ty + th) - my);
    end else begin
      word_nxt.ent_y = DIST_W'((ty + th) - my);
      word_nxt.ext_y = DIST_W'(ty - (my + mh));
    end
    word_nxt.mv_x = in_step_dx;
    word_nxt.mv_y = in_step_dy;
  end

  assign adv      = !fv_r || !q_full;
  assign in_stall = fv_r && q_full;
  assign q_push   = fv_r && !q_full;
  assign q_word   = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (adv) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

// File: sv/sbc_fifo.sv
// Small word queue between the front and back stages.
module sbc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sbc_pkg::sbc_word_t push_word,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output sbc_pkg::sbc_word_t head_word
);
  import sbc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sbc_word_t        mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign full      = (cnt_r == CW'(DEPTH));
  assign nonempty  = (cnt_r != '0);
  assign head_word = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_word;
    end
  end

endmodule

// File: sv/sbc_div.sv
// Pipelined saturating floor divider: (num << TIME_FRAC) / move, one quotient bit per stage.
module sbc_div (
  input  logic           clk,
  input  logic           en,
  input  sbc_pkg::dist_t num,
  input  sbc_pkg::move_t move,
  output sbc_pkg::time_t tval
);
  import sbc_pkg::*;

  localparam int LOW_W = QUOT_BITS - TIME_FRAC;

  logic [REM_W-1:0]     r_r   [QUOT_BITS+1];
  logic [REM_W-1:0]     m_r   [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] q_r   [QUOT_BITS+1];
  logic [LOW_W-1:0]     lo_r  [QUOT_BITS+1];
  logic                 sat_r [QUOT_BITS+1];
  logic                 neg_r [QUOT_BITS+1];

  logic [DIST_W-1:0]  dabs_w;
  logic [MOVE_W:0]    mabs_w;
  logic [DIST_W-2:0]  dabs;
  logic [REM_W-1:0]   mabs;

  assign dabs_w = num[DIST_W-1] ? DIST_W'(-num) : DIST_W'(num);
  assign mabs_w = move[MOVE_W-1] ? (MOVE_W+1)'(-$signed({move[MOVE_W-1], move}))
                                 : (MOVE_W+1)'({1'b0, move});
  assign dabs   = dabs_w[DIST_W-2:0];
  assign mabs   = mabs_w[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]   <= mabs;
      r_r[0]   <= REM_W'(dabs >> LOW_W);
      lo_r[0]  <= dabs[LOW_W-1:0];
      q_r[0]   <= '0;
      sat_r[0] <= ({1'b0, dabs} >= (DIST_W)'({mabs, {LOW_W{1'b0}}}));
      neg_r[0] <= num[DIST_W-1] ^ move[MOVE_W-1];
    end
  end

  for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_stage
    localparam int BI = QUOT_BITS - k;
    logic             nbit;
    logic [REM_W:0]   sh;
    logic [REM_W:0]   diff;
    logic             ge;
    if (BI >= TIME_FRAC) begin : g_lo
      assign nbit = lo_r[k-1][BI-TIME_FRAC];
    end else begin : g_zero
      assign nbit = 1'b0;
    end
    assign sh   = {r_r[k-1], nbit};
    assign ge   = (sh >= {1'b0, m_r[k-1]});
    assign diff = sh - {1'b0, m_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]   <= ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
        q_r[k]   <= {q_r[k-1][QUOT_BITS-2:0], ge};
        m_r[k]   <= m_r[k-1];
        lo_r[k]  <= lo_r[k-1];
        sat_r[k] <= sat_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  logic [TIME_W-1:0] qz, mag, lim;
  assign qz  = TIME_W'(q_r[QUOT_BITS]);
  assign mag = qz + TIME_W'(r_r[QUOT_BITS] != '0);
  assign lim = TIME_W'(TIME_LIMIT);

  always_comb begin
    if (!neg_r[QUOT_BITS]) begin
      tval = (sat_r[QUOT_BITS] || qz > lim) ? TIME_LIMIT : $signed(qz);
    end else begin
      tval = (sat_r[QUOT_BITS] || mag > lim) ? -TIME_LIMIT : -$signed(mag);
    end
  end

endmodule

// File: sv/sbc_back.sv
// Back stage: four dividers, side pipeline, entry/exit combine and output register.
module sbc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nonempty,
  input  sbc_pkg::sbc_word_t q_word,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_swept_overlap,
  output logic               out_hit,
  output logic [16:0]        out_entry_time,
  output logic signed [1:0]  out_normal_x,
  output logic signed [1:0]  out_normal_y
);
  import sbc_pkg::*;

  logic en;
  logic v_r     [DIV_LAT];
  logic broad_r [DIV_LAT];
  logic inx_r   [DIV_LAT];
  logic iny_r   [DIV_LAT];
  logic zx_r    [DIV_LAT];
  logic zy_r    [DIV_LAT];

  time_t ex_d, xx_d, ey_d, xy_d;
  time_t ex, xx, ey, xy, entry, exitt;
  logic  miss;

  logic              out_valid_r;
  logic              broad_out_r, hit_r;
  logic [16:0]       et_r;
  logic signed [1:0] nx_r, ny_r;

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_nonempty;

  sbc_div u_div_ex (.clk, .en, .num(q_word.ent_x), .move(q_word.mv_x), .tval(ex_d));
  sbc_div u_div_xx (.clk, .en, .num(q_word.ext_x), .move(q_word.mv_x), .tval(xx_d));
  sbc_div u_div_ey (.clk, .en, .num(q_word.ent_y), .move(q_word.mv_y), .tval(ey_d));
  sbc_div u_div_xy (.clk, .en, .num(q_word.ext_y), .move(q_word.mv_y), .tval(xy_d));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_nonempty;
      for (int i = 1; i < DIV_LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      broad_r[0] <= q_word.broad;
      inx_r[0]   <= q_word.ent_x[DIST_W-1];
      iny_r[0]   <= q_word.ent_y[DIST_W-1];
      zx_r[0]    <= (q_word.mv_x == '0);
      zy_r[0]    <= (q_word.mv_y == '0);
      for (int i = 1; i < DIV_LAT; i++) begin
        broad_r[i] <= broad_r[i-1];
        inx_r[i]   <= inx_r[i-1];
        iny_r[i]   <= iny_r[i-1];
        zx_r[i]    <= zx_r[i-1];
        zy_r[i]    <= zy_r[i-1];
      end
    end
  end

  always_comb begin
    ex    = zx_r[DIV_LAT-1] ? -TIME_LIMIT : ex_d;
    xx    = zx_r[DIV_LAT-1] ?  TIME_LIMIT : xx_d;
    ey    = zy_r[DIV_LAT-1] ? -TIME_LIMIT : ey_d;
    xy    = zy_r[DIV_LAT-1] ?  TIME_LIMIT : xy_d;
    entry = (ex > ey) ? ex : ey;
    exitt = (xx < xy) ? xx : xy;
    miss  = (entry > exitt) || (ex < 0 && ey < 0) || (ex > TIME_ONE) || (ey > TIME_ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en && v_r[DIV_LAT-1]) begin
      broad_out_r <= broad_r[DIV_LAT-1];
      hit_r       <= !miss;
      nx_r        <= NORM_NONE;
      ny_r        <= NORM_NONE;
      if (miss) begin
        et_r <= TIME_ONE[16:0];
      end else begin
        et_r <= entry[16:0];
        if (ex > ey) begin
          nx_r <= inx_r[DIV_LAT-1] ? NORM_POS : NORM_NEG;
        end else begin
          ny_r <= iny_r[DIV_LAT-1] ? NORM_POS : NORM_NEG;
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_swept_overlap = broad_out_r;
  assign out_hit           = hit_r;
  assign out_entry_time    = et_r;
  assign out_normal_x      = nx_r;
  assign out_normal_y      = ny_r;

endmodule

// File: sv/swept_box_collision.sv
// Top level of the 2D swept box collision test.
//
// Input channel (in_*): one word per pair, a moving box with its step
// displacement and a static box, coordinates in Q12.4.
// Output channel (out_*): one word per input word, in order: broadphase
// flag, hit flag, entry time in Q1.16 (1.0 on a miss) and the normal.
// Both channels: a word moves when valid is high and stall is low.
// Throughput is one word per cycle while neither channel stalls. A word passes
// from the front register into the queue, then through the four
// bit-per-stage dividers (18 quotient bits plus setup) and one output
// register, and it may wait in the queue on the way.
// A stall on a valid output word freezes the divider pipeline; the front keeps
// accepting until the QUEUE_DEPTH word queue fills, then raises in_stall.
// Reset (rst_n low, synchronous) empties the front, queue and pipeline.
module swept_box_collision #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [16:0] in_mover_x,
  input  logic signed [16:0] in_mover_y,
  input  logic        [15:0] in_mover_width,
  input  logic        [15:0] in_mover_height,
  input  logic signed [12:0] in_step_dx,
  input  logic signed [12:0] in_step_dy,
  input  logic signed [16:0] in_target_x,
  input  logic signed [16:0] in_target_y,
  input  logic        [15:0] in_target_width,
  input  logic        [15:0] in_target_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_swept_overlap,
  output logic               out_hit,
  output logic        [16:0] out_entry_time,
  output logic signed [1:0]  out_normal_x,
  output logic signed [1:0]  out_normal_y
);
  import sbc_pkg::*;

  sbc_word_t push_word, head_word;
  logic      push, full, pop, nonempty;

  sbc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_mover_x, .in_mover_y, .in_mover_width, .in_mover_height,
    .in_step_dx, .in_step_dy,
    .in_target_x, .in_target_y, .in_target_width, .in_target_height,
    .q_full(full), .q_push(push), .q_word(push_word)
  );

  sbc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst_n, .push, .push_word, .full, .pop, .nonempty, .head_word
  );

  sbc_back u_back (
    .clk, .rst_n, .q_nonempty(nonempty), .q_word(head_word), .q_pop(pop),
    .out_valid, .out_stall, .out_swept_overlap, .out_hit, .out_entry_time,
    .out_normal_x, .out_normal_y
  );

endmodule

// File: sv/sbc_check.sv
// Port-level checks for the swept box collision block, bound to the top level.
module sbc_check (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_hit,
  input logic [16:0]       out_entry_time,
  input logic signed [1:0] out_normal_x,
  input logic signed [1:0] out_normal_y
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_time) && $stable(out_hit))
    else $error("stalled output word changed");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_entry_time == 17'h10000 &&
                              out_normal_x == 2'sb00 && out_normal_y == 2'sb00)
    else $error("miss word not at time one with zero normal");

  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_normal_x != 2'sb00) != (out_normal_y != 2'sb00))
    else $error("hit word needs exactly one normal axis");

  a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_entry_time <= 17'h10000)
    else $error("hit entry time above one");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind swept_box_collision sbc_check u_sbc_check (.*);

// File: bench/tb_swept_box_collision.sv
// Testbench for swept_box_collision: directed and random box pairs checked against a predictor.
module tb_swept_box_collision;
  import sbc_pkg::*;

  typedef struct {
    logic signed [16:0] mx, my, tx, ty;
    logic [15:0] mw, mh, tw, th;
    logic signed [12:0] dx, dy;
  } pair_t;

  typedef struct {
    logic ovl, hit;
    logic [16:0] t;
    logic signed [1:0] nx, ny;
  } contact_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic long_hold = 0;
  logic in_stall, out_valid;
  logic signed [16:0] in_mover_x = 0, in_mover_y = 0, in_target_x = 0, in_target_y = 0;
  logic [15:0] in_mover_width = 0, in_mover_height = 0, in_target_width = 0;
  logic [15:0] in_target_height = 0;
  logic signed [12:0] in_step_dx = 0, in_step_dy = 0;
  logic out_swept_overlap, out_hit;
  logic [16:0] out_entry_time;
  logic signed [1:0] out_normal_x, out_normal_y;

  contact_t expected_contacts[$];
  int mismatches = 0, results_seen = 0, hits_seen = 0, items_sent = 0;
  int send_idle_pct = 0, stall_pct = 0;

  swept_box_collision dut (.*);

  always #1 clk = ~clk;

  function automatic longint floor_time(longint dist_v, longint mv);
    longint n, q;
    n = dist_v * 65536;
    q = n / mv;
    if ((n % mv) != 0 && ((n < 0) != (mv < 0))) q = q - 1;
    if (q > 131072) q = 131072;
    if (q < -131072) q = -131072;
    return q;
  endfunction

  function automatic void axis_span(input longint mp, ms, mv, tp, ts,
                                    output longint ent_d, t_ent, t_ext);
    longint ext_d;
    if (mv > 0) begin
      ent_d = tp - (mp + ms);
      ext_d = (tp + ts) - mp;
    end else begin
      ent_d = (tp + ts) - mp;
      ext_d = tp - (mp + ms);
    end
    if (mv == 0) begin
      t_ent = -131072;
      t_ext = 131072;
    end else begin
      t_ent = floor_time(ent_d, mv);
      t_ext = floor_time(ext_d, mv);
    end
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint mx, my, mw, mh, dx, dy, tx, ty, tw, th, bx, by, bw, bh;
    longint ix, iy, ex, ey, xx, xy, ent, ext;
    logic miss;
    mx = p.mx; my = p.my; mw = p.mw; mh = p.mh; dx = p.dx; dy = p.dy;
    tx = p.tx; ty = p.ty; tw = p.tw; th = p.th;
    bx = dx > 0 ? mx : mx + dx;
    by = dy > 0 ? my : my + dy;
    bw = dx > 0 ? dx + mw : mw - dx;
    bh = dy > 0 ? dy + mh : mh - dy;
    c.ovl = !(bx + bw < tx || bx > tx + tw || by + bh < ty || by > ty + th);
    axis_span(mx, mw, dx, tx, tw, ix, ex, xx);
    axis_span(my, mh, dy, ty, th, iy, ey, xy);
    ent = ex > ey ? ex : ey;
    ext = xx < xy ? xx : xy;
    miss = ent > ext || (ex < 0 && ey < 0) || ex > 65536 || ey > 65536;
    c.hit = !miss;
    c.nx = NORM_NONE;
    c.ny = NORM_NONE;
    if (miss) c.t = 17'h10000;
    else begin
      c.t = ent[16:0];
      if (ex > ey) c.nx = ix < 0 ? NORM_POS : NORM_NEG;
      else c.ny = iy < 0 ? NORM_POS : NORM_NEG;
    end
    return c;
  endfunction

  task automatic send_pair(input pair_t p);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_mover_x <= p.mx; in_mover_y <= p.my;
    in_mover_width <= p.mw; in_mover_height <= p.mh;
    in_step_dx <= p.dx; in_step_dy <= p.dy;
    in_target_x <= p.tx; in_target_y <= p.ty;
    in_target_width <= p.tw; in_target_height <= p.th;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_contacts.push_back(predict_contact(p));
    items_sent++;
  endtask

  function automatic pair_t any_pair();
    pair_t p;
    p.mx = 17'($urandom); p.my = 17'($urandom);
    p.tx = 17'($urandom); p.ty = 17'($urandom);
    p.mw = 16'($urandom); p.mh = 16'($urandom);
    p.tw = 16'($urandom); p.th = 16'($urandom);
    p.dx = 13'($urandom); p.dy = 13'($urandom);
    return p;
  endfunction

  // Pairs placed near each other so sweeps actually strike.
  function automatic pair_t near_pair();
    pair_t p;
    p.mx = 17'($urandom_range(2000) - 1000);
    p.my = 17'($urandom_range(2000) - 1000);
    p.mw = 16'($urandom_range(400));
    p.mh = 16'($urandom_range(400));
    p.tx = 17'(p.mx + $urandom_range(1600) - 800);
    p.ty = 17'(p.my + $urandom_range(1600) - 800);
    p.tw = 16'($urandom_range(400));
    p.th = 16'($urandom_range(400));
    p.dx = $urandom_range(1) ? 13'sd0 : 13'($urandom_range(3000) - 1500);
    p.dy = $urandom_range(3) == 0 ? 13'sd0 : 13'($urandom_range(3000) - 1500);
    return p;
  endfunction

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= long_hold || (stall_pct > 0 && $urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      contact_t e;
      results_seen++;
      if (out_hit) hits_seen++;
      if (expected_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word at %0t", $time);
      end else begin
        e = expected_contacts.pop_front();
        if (e.ovl !== out_swept_overlap || e.hit !== out_hit || e.t !== out_entry_time ||
            e.nx !== out_normal_x || e.ny !== out_normal_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ovl=%b hit=%b t=%h n=%0d,%0d",
                     e.ovl, e.hit, e.t, e.nx, e.ny,
                     " got ovl=%b hit=%b t=%h n=%0d,%0d",
                     out_swept_overlap, out_hit, out_entry_time,
                     out_normal_x, out_normal_y);
        end
      end
    end
  end

  task automatic test_directed();
    pair_t p;
    p = '{mx: 0, my: 0, tx: 160, ty: 0, mw: 16, mh: 16, tw: 16, th: 16, dx: 320, dy: 0};
    send_pair(p);                      // head-on hit in x
    p.dx = -320; send_pair(p);         // moving away
    p.dx = 0; p.dy = 0; send_pair(p);  // both axes still
    p.tx = 0; p.ty = 160; p.dy = 320; send_pair(p); // hit in y
    p.tx = 16; p.ty = 0; p.dx = 0; p.dy = 0; send_pair(p); // edges touching
    p = '{mx: -65536, my: -65536, tx: 65535, ty: 65535, mw: 16'hffff, mh: 16'hffff,
          tw: 16'hffff, th: 16'hffff, dx: -4096, dy: 4095};
    send_pair(p);
    p.mx = 65535; p.my = 65535; p.tx = -65536; p.ty = -65536; p.dx = 4095; p.dy = -4096;
    send_pair(p);
    p = '{mx: 0, my: 0, tx: 100, ty: 100, mw: 0, mh: 0, tw: 0, th: 0, dx: 100, dy: 100};
    send_pair(p);                      // diagonal tie, normal on y
    p.dx = 1; p.dy = -1; send_pair(p); // saturated times
    p = '{mx: 0, my: 0, tx: -200, ty: -300, mw: 50, mh: 50, tw: 100, th: 100,
          dx: -4096, dy: -4096};
    send_pair(p);
    repeat (10) send_pair(any_pair());
    wait_drained();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_pair($urandom_range(3) == 0 ? any_pair() : near_pair());
    wait_drained();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        long_hold <= 1'b1;
        repeat (200) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
    repeat (40) send_pair(near_pair());
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(50, 0, 0);
    test_random(300, 82, 0);
    test_random(300, 0, 82);
    test_random(300, 29, 29);
    test_backpressure();
    $display("Sent %0d box pairs, %0d results checked, %0d hits, under all stall mixes.",
             items_sent, results_seen, hits_seen);
    if (mismatches == 0 && expected_contacts.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end
endmodule
